>>> hw/rtl/hpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int CNT_W = 7;
    localparam int ST_W  = 2;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] top_value;
        logic [CNT_W-1:0]        entry_count;
    } t_hpq_res;

endpackage

>>> hw/rtl/hpq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_if
// Valid/ready channels for heap requests and heap results.
// ----------------------------------------------------------------------------
interface hpq_req_if import hpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output req_type, output value, output position,
                    input ready);
    modport sink   (input valid, input req_type, input value, input position,
                    output ready);
endinterface

interface hpq_res_if import hpq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] top_value;
    logic [CNT_W-1:0]        entry_count;

    modport source (output valid, output status, output top_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input top_value,
                    input entry_count, output ready);
endinterface

>>> hw/rtl/hpq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_mem
// Heap storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module hpq_mem import hpq_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    i_clk,
    input  logic [AW-1:0]           i_rd_addr_a,
    input  logic [AW-1:0]           i_rd_addr_b,
    output logic signed [VAL_W-1:0] o_rd_data_a,
    output logic signed [VAL_W-1:0] o_rd_data_b,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [VAL_W-1:0] i_wr_data
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_a;
    logic signed [VAL_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> hw/rtl/hpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ctrl
// Request sequencer: validates requests, walks sift-up then sift-down one
// level per cycle with the moving value held in a register, reads the top.
// ----------------------------------------------------------------------------
module hpq_ctrl import hpq_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int PW       = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    hpq_req_if.sink                 i_req,
    output logic                    o_res_valid,
    output t_hpq_res                o_res,
    input  logic                    i_res_take,
    output logic [AW-1:0]           o_rd_addr_a,
    output logic [AW-1:0]           o_rd_addr_b,
    input  logic signed [VAL_W-1:0] i_rd_data_a,
    input  logic signed [VAL_W-1:0] i_rd_data_b,
    output logic                    o_wr_en,
    output logic [AW-1:0]           o_wr_addr,
    output logic signed [VAL_W-1:0] o_wr_data
);

    localparam int CHW = PW + 1;
    localparam int CMW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DEL_RD  = 3'd1;
    localparam logic [2:0] S_UP      = 3'd2;
    localparam logic [2:0] S_DN      = 3'd3;
    localparam logic [2:0] S_FIN_RD  = 3'd4;
    localparam logic [2:0] S_FIN_OUT = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [PW-1:0]           r_cnt, n_cnt;
    logic [PW-1:0]           r_pos, n_pos;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [ST_W-1:0]         r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
    end

    always_comb begin
        logic [PW-1:0]           ins_pos;
        logic [PW-1:0]           parent;
        logic [CHW-1:0]          left;
        logic [CHW-1:0]          child;
        logic signed [VAL_W-1:0] big;

        ins_pos = r_cnt + 1'b1;
        parent  = r_pos >> 1;
        left    = {r_pos, 1'b0};
        child   = left;
        big     = i_rd_data_a;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        o_rd_addr_a = '0;
        o_rd_addr_b = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = AW'(r_pos - 1'b1);
        o_wr_data   = r_val;
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_val    = i_req.value;
                    n_status = ST_DONE;
                    if (i_req.req_type == REQ_INSERT) begin
                        if (r_cnt == CAP_P) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN_RD;
                        end else begin
                            n_cnt       = ins_pos;
                            n_pos       = ins_pos;
                            o_rd_addr_a = AW'((ins_pos >> 1) - 1'b1);
                            n_state     = S_UP;
                        end
                    end else begin
                        if (i_req.position == '0 ||
                            CMW'(i_req.position) > CMW'(r_cnt)) begin
                            n_status = ST_BADPOS;
                            n_state  = S_FIN_RD;
                        end else begin
                            n_cnt = r_cnt - 1'b1;
                            n_pos = PW'(i_req.position);
                            if (CMW'(i_req.position) == CMW'(r_cnt)) begin
                                // last entry removed, nothing to repair
                                n_state = S_FIN_RD;
                            end else begin
                                o_rd_addr_a = AW'(r_cnt - 1'b1);
                                n_state     = S_DEL_RD;
                            end
                        end
                    end
                end
            end
            S_DEL_RD: begin
                // last entry becomes the value that fills the hole
                n_val       = i_rd_data_a;
                o_rd_addr_a = AW'(parent - 1'b1);
                n_state     = S_UP;
            end
            S_UP: begin
                if (r_pos > PW'(1) && i_rd_data_a < r_val) begin
                    o_wr_en     = 1'b1;
                    o_wr_data   = i_rd_data_a;
                    n_pos       = parent;
                    o_rd_addr_a = AW'((parent >> 1) - 1'b1);
                end else begin
                    o_rd_addr_a = AW'(left - 1'b1);
                    o_rd_addr_b = AW'(left);
                    n_state     = S_DN;
                end
            end
            S_DN: begin
                if (left > CHW'(r_cnt)) begin
                    o_wr_en = 1'b1;
                    n_state = S_FIN_RD;
                end else begin
                    if (left + 1'b1 <= CHW'(r_cnt) && i_rd_data_b > i_rd_data_a) begin
                        child = left + 1'b1;
                        big   = i_rd_data_b;
                    end
                    o_wr_en = 1'b1;
                    if (r_val < big) begin
                        o_wr_data   = big;
                        n_pos       = PW'(child);
                        o_rd_addr_a = AW'({child, 1'b0} - 1'b1);
                        o_rd_addr_b = AW'({child, 1'b0});
                    end else begin
                        n_state = S_FIN_RD;
                    end
                end
            end
            S_FIN_RD: begin
                n_state = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.status      = r_status;
    assign o_res.top_value   = (r_cnt == '0) ? '0 : i_rd_data_a;
    assign o_res.entry_count = CNT_W'(r_cnt);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_P)
        else $error("held count above capacity");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (CHW'(o_wr_addr) < CHW'(r_cnt)))
        else $error("heap write outside held entries");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.req_type == REQ_INSERT &&
         r_cnt != CAP_P) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("insert did not grow the heap");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_FIN_OUT) |-> !o_wr_en)
        else $error("heap write outside a request");

endmodule

>>> hw/rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit values with insert and positional delete.
//
//   channel | dir | fields                               | transfer when
//   i_req   | in  | req_type, value, position            | valid && ready
//   o_res   | out | status, top_value, entry_count       | valid && ready
//
// One request at a time. Each heap level moved is one step on the single
// storage memory (two read ports, one write port); a delete first reads the
// last entry that fills the hole. Rejected requests and a delete of the last
// entry skip the sift and go straight to reading the top.
// Reset clears the state, the count and the output valid; the storage is not swept.
// A result waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import hpq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpq_req_if.sink    i_req,
    hpq_res_if.source  o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);

    logic                    res_valid;
    logic                    res_take;
    t_hpq_res                res;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic signed [VAL_W-1:0] rd_data_a;
    logic signed [VAL_W-1:0] rd_data_b;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    logic                    r_out_valid;
    t_hpq_res                r_out;

    hpq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .PW       (PW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    hpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data)
    );

    // output slot frees up when the held result transfers
    assign res_take = res_valid && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.top_value   = r_out.top_value;
    assign o_res.entry_count = r_out.entry_count;

endmodule
